// ===== rtl/core/sdtq_pkg.sv =====
// Shared types, codes and constants of the sorted deadline timer queue.
package sdtq_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int TIME_BITS_DEFAULT = 32;
   localparam int PORT_TIME_BITS    = 32;
   localparam int REQ_BITS          = 2;
   localparam int ID_BITS           = 4;
   localparam int ID_COUNT          = 1 << ID_BITS;
   localparam int KIND_BITS         = 3;
   localparam int WAIT_BITS         = 31;

   localparam logic [WAIT_BITS-1:0] WAIT_MAX = '1;

   typedef enum logic [REQ_BITS-1:0] {
      REQ_ADD = 2'd0,
      REQ_DEL = 2'd1,
      REQ_ADV = 2'd2,
      REQ_NOP = 2'd3
   } req_code_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_OK      = 3'd0,
      KIND_EXPIRED = 3'd1,
      KIND_WAIT    = 3'd2,
      KIND_EMPTY   = 3'd3,
      KIND_BUSY    = 3'd4,
      KIND_ABSENT  = 3'd5,
      KIND_FULL    = 3'd6
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_INS_SCAN,
      ST_INS_SHIFT,
      ST_INS_PUT,
      ST_DEL_SCAN,
      ST_DEL_SHIFT,
      ST_ADV,
      ST_REPLY
   } state_type;

   // read address, relative to the head of the queue
   typedef enum logic [2:0] {
      RD_ZERO,
      RD_ONE,
      RD_SCAN,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic [1:0] {
      SCAN_HOLD,
      SCAN_ZERO,
      SCAN_INC
   } scan_op_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_SHIFT_UP,
      WR_NEW_UP,
      WR_NEW_HERE,
      WR_NEW_ZERO,
      WR_SHIFT_DOWN
   } wr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_POP
   } cnt_op_type;

   typedef enum logic [1:0] {
      PEND_HOLD,
      PEND_SET,
      PEND_CLR,
      PEND_CLR_HEAD
   } pend_op_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_KIND,
      EMIT_EXPIRED,
      EMIT_WAIT,
      EMIT_EMPTY
   } emit_op_type;

   typedef struct packed {
      logic        load;
      rd_sel_type  rd_sel;
      scan_op_type scan_op;
      wr_op_type   wr_op;
      cnt_op_type  cnt_op;
      pend_op_type pend_op;
      logic        set_kind;
      kind_type    kind;
      emit_op_type emit_op;
   } cmd_type;

   typedef struct packed {
      req_code_type req_code;
      logic         is_pending;
      logic         full;
      logic         empty;
      logic         scan_at_end;
      logic         id_match;
      logic         head_later;
      logic         ins_later;
      logic         out_free;
   } status_type;

   localparam cmd_type CMD_NONE = '{
      load:     1'b0,
      rd_sel:   RD_ZERO,
      scan_op:  SCAN_HOLD,
      wr_op:    WR_NONE,
      cnt_op:   CNT_HOLD,
      pend_op:  PEND_HOLD,
      set_kind: 1'b0,
      kind:     KIND_OK,
      emit_op:  EMIT_NONE
   };

endpackage

// ===== rtl/core/sdtq_req_if.sv =====
// Request channel of the timer queue: valid, ready and one request word.
interface sdtq_req_if import sdtq_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [REQ_BITS-1:0]       req_type;
   logic [ID_BITS-1:0]        timer_id;
   logic [PORT_TIME_BITS-1:0] deadline_ms;
   logic [PORT_TIME_BITS-1:0] now_ms;

   modport source (output valid, req_type, timer_id, deadline_ms, now_ms, input ready);
   modport sink (input valid, req_type, timer_id, deadline_ms, now_ms, output ready);
endinterface

// ===== rtl/core/sdtq_rsp_if.sv =====
// Response channel of the timer queue: valid, ready and one result word.
interface sdtq_rsp_if import sdtq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KIND_BITS-1:0] result_kind;
   logic [ID_BITS-1:0]   expired_id;
   logic [WAIT_BITS-1:0] wait_ms;
   logic                 last_result;

   modport source (output valid, result_kind, expired_id, wait_ms, last_result, input ready);
   modport sink (input valid, result_kind, expired_id, wait_ms, last_result, output ready);
endinterface

// ===== rtl/core/sorted_deadline_timer_queue.sv =====
// Top level of the sorted deadline timer queue: controller, datapath and channel ports.
//
//   channel  dir  handshake      word
//   req_ch   in   valid / ready  req_type, timer_id, deadline_ms, now_ms
//   rsp_ch   out  valid / ready  result_kind, expired_id, wait_ms, last_result
//
// One request at a time. Between dispatch and reply, add and delete read the ring entries
// in turn through the single read port of the entry RAM, and add writes its new entry
// into the ring as it goes. Advance emits one expired word per expired head, then a wait
// or empty word. The sequencer returns to idle as the last result word enters the output
// register and takes a new request while that word still waits there.
// Synchronous reset empties the queue and clears every pending bit at once; no
// clearing pass. A stalled rsp_ch holds the sequencer in its reply or advance state.
module sorted_deadline_timer_queue import sdtq_pkg::*; #(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   sdtq_req_if.sink   req_ch,
   sdtq_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type stat;

   sdtq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sdtq_datapath #(
      .DEPTH     (DEPTH),
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_type    (req_ch.req_type),
      .timer_id    (req_ch.timer_id),
      .deadline_ms (req_ch.deadline_ms),
      .now_ms      (req_ch.now_ms),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .result_kind (rsp_ch.result_kind),
      .expired_id  (rsp_ch.expired_id),
      .wait_ms     (rsp_ch.wait_ms),
      .last_result (rsp_ch.last_result)
   );

endmodule

// ===== rtl/core/sdtq_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module sdtq_ram import sdtq_pkg::*; #(
   parameter int WIDTH = ID_BITS + TIME_BITS_DEFAULT,
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sdtq_datapath.sv =====
// Datapath of the timer queue: ring of sorted entries, pending bits, result register.
module sdtq_datapath import sdtq_pkg::*; #(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [REQ_BITS-1:0]       req_type,
   input  logic [ID_BITS-1:0]        timer_id,
   input  logic [PORT_TIME_BITS-1:0] deadline_ms,
   input  logic [PORT_TIME_BITS-1:0] now_ms,
   input  cmd_type                   cmd,
   output status_type                stat,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [KIND_BITS-1:0]      result_kind,
   output logic [ID_BITS-1:0]        expired_id,
   output logic [WAIT_BITS-1:0]      wait_ms,
   output logic                      last_result
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = ID_BITS + TIME_BITS;

   // latched request
   req_code_type         req_code_ff;
   logic [ID_BITS-1:0]   req_id_ff;
   logic [TIME_BITS-1:0] req_dl_ff;
   logic [TIME_BITS-1:0] req_now_ff;

   logic [IW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        scan_ff, scan_in;
   logic [ID_COUNT-1:0]  pending_ff, pending_in;
   kind_type             kind_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_BITS-1:0] rsp_kind_ff, rsp_kind_in;
   logic [ID_BITS-1:0]   rsp_id_ff, rsp_id_in;
   logic [WAIT_BITS-1:0] rsp_wait_ff, rsp_wait_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [CW-1:0]        rd_log, wr_log;
   logic [IW-1:0]        rd_addr, wr_addr;
   logic                 wr_en;
   logic [EW-1:0]        wr_word, rd_word;
   logic [ID_BITS-1:0]   rd_id;
   logic [TIME_BITS-1:0] rd_dl;
   logic [TIME_BITS-1:0] gap;
   logic [63:0]          gap_wide;
   logic [WAIT_BITS-1:0] wait_val;
   logic [CW:0]          scan_next;

   // map a position behind the head onto a ring address
   function automatic logic [IW-1:0] ring_addr(input logic [IW-1:0] head,
                                                input logic [CW-1:0] pos);
      logic [CW:0] sum;
      sum = (CW+1)'(head) + (CW+1)'(pos);
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   // true when time a lies after time b, wrap-safe
   function automatic logic later(input logic [TIME_BITS-1:0] a,
                                  input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS-1:0] d;
      d = b - a;
      return d[TIME_BITS-1];
   endfunction

   assign rd_id = rd_word[TIME_BITS +: ID_BITS];
   assign rd_dl = rd_word[TIME_BITS-1:0];

   sdtq_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   always_comb begin
      unique case (cmd.rd_sel)
         RD_ZERO: rd_log = '0;
         RD_ONE:  rd_log = CW'(1);
         RD_SCAN: rd_log = scan_ff;
         RD_NEXT: rd_log = scan_ff + CW'(1);
         default: rd_log = '0;
      endcase
      rd_addr = ring_addr(head_ff, rd_log);
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_log  = scan_ff + CW'(1);
      wr_word = rd_word;
      unique case (cmd.wr_op)
         WR_NONE: begin
            wr_en = 1'b0;
         end
         WR_SHIFT_UP: begin
            wr_log = scan_ff + CW'(1);
         end
         WR_NEW_UP: begin
            wr_word = {req_id_ff, req_dl_ff};
         end
         WR_NEW_HERE: begin
            wr_log  = scan_ff;
            wr_word = {req_id_ff, req_dl_ff};
         end
         WR_NEW_ZERO: begin
            wr_log  = '0;
            wr_word = {req_id_ff, req_dl_ff};
         end
         WR_SHIFT_DOWN: begin
            wr_log = scan_ff - CW'(1);
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
      wr_addr = ring_addr(head_ff, wr_log);
   end

   // time left to the head deadline, clipped to the result field
   assign gap      = rd_dl - req_now_ff;
   assign gap_wide = 64'(gap);
   assign wait_val = (gap_wide > 64'(WAIT_MAX)) ? WAIT_MAX : gap_wide[WAIT_BITS-1:0];

   assign scan_next = (CW+1)'(scan_ff) + (CW+1)'(1);

   always_comb begin
      stat.req_code    = req_code_ff;
      stat.is_pending  = pending_ff[req_id_ff];
      stat.full        = (count_ff == CW'(DEPTH));
      stat.empty       = (count_ff == '0);
      stat.scan_at_end = (scan_next >= (CW+1)'(count_ff));
      stat.id_match    = (rd_id == req_id_ff);
      stat.head_later  = later(rd_dl, req_now_ff);
      stat.ins_later   = later(rd_dl, req_dl_ff);
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      scan_in = scan_ff;
      unique case (cmd.scan_op)
         SCAN_HOLD: scan_in = scan_ff;
         SCAN_ZERO: scan_in = '0;
         SCAN_INC:  scan_in = scan_ff + CW'(1);
         default:   scan_in = scan_ff;
      endcase
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      unique case (cmd.cnt_op)
         CNT_HOLD: count_in = count_ff;
         CNT_INC:  count_in = count_ff + CW'(1);
         CNT_DEC:  count_in = count_ff - CW'(1);
         CNT_POP: begin
            count_in = count_ff - CW'(1);
            head_in  = ring_addr(head_ff, CW'(1));
         end
         default:  count_in = count_ff;
      endcase
   end

   always_comb begin
      pending_in = pending_ff;
      unique case (cmd.pend_op)
         PEND_HOLD:     pending_in = pending_ff;
         PEND_SET:      pending_in[req_id_ff] = 1'b1;
         PEND_CLR:      pending_in[req_id_ff] = 1'b0;
         PEND_CLR_HEAD: pending_in[rd_id] = 1'b0;
         default:       pending_in = pending_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_wait_in  = rsp_wait_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit_op != EMIT_NONE) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = '0;
         rsp_wait_in  = '0;
         rsp_last_in  = 1'b1;
      end
      unique case (cmd.emit_op)
         EMIT_NONE: ;
         EMIT_KIND: rsp_kind_in = kind_ff;
         EMIT_EXPIRED: begin
            rsp_kind_in = KIND_EXPIRED;
            rsp_id_in   = rd_id;
            rsp_last_in = 1'b0;
         end
         EMIT_WAIT: begin
            rsp_kind_in = KIND_WAIT;
            rsp_wait_in = wait_val;
         end
         EMIT_EMPTY: rsp_kind_in = KIND_EMPTY;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_code_ff <= req_code_type'(req_type);
         req_id_ff   <= timer_id;
         req_dl_ff   <= TIME_BITS'(deadline_ms);
         req_now_ff  <= TIME_BITS'(now_ms);
      end
      if (cmd.set_kind) begin
         kind_ff <= cmd.kind;
      end
      scan_ff     <= scan_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_wait_ff <= rsp_wait_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign result_kind = rsp_kind_ff;
   assign expired_id  = rsp_id_ff;
   assign wait_ms     = rsp_wait_ff;
   assign last_result = rsp_last_ff;

endmodule

// ===== rtl/core/sdtq_controller.sv =====
// Controller of the timer queue: sequences insert, delete and advance over the ring.
module sdtq_controller import sdtq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type stat,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (stat.req_code)
               REQ_ADD: begin
                  if (stat.is_pending || stat.full) begin
                     state_in = ST_REPLY;
                  end else if (stat.empty) begin
                     state_in = ST_INS_PUT;
                  end else begin
                     state_in = ST_INS_SCAN;
                  end
               end
               REQ_DEL: begin
                  if (!stat.is_pending || stat.empty) begin
                     state_in = ST_REPLY;
                  end else begin
                     state_in = ST_DEL_SCAN;
                  end
               end
               REQ_ADV: state_in = ST_ADV;
               default: state_in = ST_REPLY;
            endcase
         end
         ST_INS_SCAN: begin
            if (stat.ins_later) begin
               state_in = ST_INS_SHIFT;
            end else if (stat.scan_at_end) begin
               state_in = ST_REPLY;
            end
         end
         ST_INS_SHIFT: begin
            if (stat.scan_at_end) begin
               state_in = ST_REPLY;
            end
         end
         ST_INS_PUT: state_in = ST_REPLY;
         ST_DEL_SCAN: begin
            if (stat.id_match) begin
               state_in = stat.scan_at_end ? ST_REPLY : ST_DEL_SHIFT;
            end else if (stat.scan_at_end) begin
               state_in = ST_REPLY;
            end
         end
         ST_DEL_SHIFT: begin
            if (stat.scan_at_end) begin
               state_in = ST_REPLY;
            end
         end
         ST_ADV: begin
            if (stat.out_free && (stat.empty || stat.head_later)) begin
               state_in = ST_IDLE;
            end
         end
         ST_REPLY: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DISPATCH: begin
            unique case (stat.req_code)
               REQ_ADD: begin
                  if (stat.is_pending) begin
                     cmd.set_kind = 1'b1;
                     cmd.kind     = KIND_BUSY;
                  end else if (stat.full) begin
                     cmd.set_kind = 1'b1;
                     cmd.kind     = KIND_FULL;
                  end else if (!stat.empty) begin
                     // start from the head and walk towards the tail
                     cmd.rd_sel  = RD_ZERO;
                     cmd.scan_op = SCAN_ZERO;
                  end
               end
               REQ_DEL: begin
                  if (!stat.is_pending) begin
                     cmd.set_kind = 1'b1;
                     cmd.kind     = KIND_ABSENT;
                  end else begin
                     cmd.pend_op = PEND_CLR;
                     if (stat.empty) begin
                        cmd.set_kind = 1'b1;
                        cmd.kind     = KIND_ABSENT;
                     end else begin
                        cmd.rd_sel  = RD_ZERO;
                        cmd.scan_op = SCAN_ZERO;
                     end
                  end
               end
               REQ_ADV: cmd.rd_sel = RD_ZERO;
               default: begin
                  cmd.set_kind = 1'b1;
                  cmd.kind     = KIND_OK;
               end
            endcase
         end
         ST_INS_SCAN: begin
            if (stat.ins_later) begin
               // take the slot of the first later entry and read it back to move it on
               cmd.wr_op   = WR_NEW_HERE;
               cmd.pend_op = PEND_SET;
               cmd.rd_sel  = RD_SCAN;
            end else if (stat.scan_at_end) begin
               cmd.wr_op    = WR_NEW_UP;
               cmd.cnt_op   = CNT_INC;
               cmd.pend_op  = PEND_SET;
               cmd.set_kind = 1'b1;
               cmd.kind     = KIND_OK;
            end else begin
               cmd.rd_sel  = RD_NEXT;
               cmd.scan_op = SCAN_INC;
            end
         end
         ST_INS_SHIFT: begin
            // move each entry one place back; the read returns the word before this write
            cmd.wr_op = WR_SHIFT_UP;
            if (stat.scan_at_end) begin
               cmd.cnt_op   = CNT_INC;
               cmd.set_kind = 1'b1;
               cmd.kind     = KIND_OK;
            end else begin
               cmd.rd_sel  = RD_NEXT;
               cmd.scan_op = SCAN_INC;
            end
         end
         ST_INS_PUT: begin
            cmd.wr_op    = WR_NEW_ZERO;
            cmd.cnt_op   = CNT_INC;
            cmd.pend_op  = PEND_SET;
            cmd.set_kind = 1'b1;
            cmd.kind     = KIND_OK;
         end
         ST_DEL_SCAN: begin
            if (stat.id_match && stat.scan_at_end) begin
               cmd.cnt_op   = CNT_DEC;
               cmd.set_kind = 1'b1;
               cmd.kind     = KIND_OK;
            end else if (!stat.id_match && stat.scan_at_end) begin
               cmd.set_kind = 1'b1;
               cmd.kind     = KIND_ABSENT;
            end else begin
               cmd.rd_sel  = RD_NEXT;
               cmd.scan_op = SCAN_INC;
            end
         end
         ST_DEL_SHIFT: begin
            // close the gap left by the removed entry
            cmd.wr_op = WR_SHIFT_DOWN;
            if (stat.scan_at_end) begin
               cmd.cnt_op   = CNT_DEC;
               cmd.set_kind = 1'b1;
               cmd.kind     = KIND_OK;
            end else begin
               cmd.rd_sel  = RD_NEXT;
               cmd.scan_op = SCAN_INC;
            end
         end
         ST_ADV: begin
            cmd.rd_sel = RD_ZERO;
            if (stat.out_free) begin
               if (stat.empty) begin
                  cmd.emit_op = EMIT_EMPTY;
               end else if (stat.head_later) begin
                  cmd.emit_op = EMIT_WAIT;
               end else begin
                  // pop the head and fetch the one behind it
                  cmd.emit_op = EMIT_EXPIRED;
                  cmd.cnt_op  = CNT_POP;
                  cmd.pend_op = PEND_CLR_HEAD;
                  cmd.rd_sel  = RD_ONE;
               end
            end
         end
         ST_REPLY: begin
            if (stat.out_free) begin
               cmd.emit_op = EMIT_KIND;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== tb/tb_sorted_deadline_timer_queue.sv =====
// Self-checking testbench for the sorted deadline timer queue: stimulus, predictor, checks.
`timescale 1ns / 1ps

module tb_sorted_deadline_timer_queue;
   import sdtq_pkg::*;

   localparam int TQ_DEPTH   = DEPTH_DEFAULT;
   localparam int IDLE_LIMIT = 3000;
   localparam int RANDOM_REQS = 410;

   typedef struct {
      req_code_type         code;
      logic [ID_BITS-1:0]   id;
      logic [31:0]          deadline_ms;
      logic [31:0]          now_ms;
   } timer_req_type;

   typedef struct {
      kind_type             kind;
      logic [ID_BITS-1:0]   id;
      logic [WAIT_BITS-1:0] wait_ms;
      logic                 last;
   } timer_reply_type;

   logic clock;
   logic reset;

   sdtq_req_if req_if ();
   sdtq_rsp_if rsp_if ();

   sorted_deadline_timer_queue dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // shadow of the timer queue
   logic [ID_BITS-1:0] tq_ids       [TQ_DEPTH];
   logic [31:0]        tq_deadlines [TQ_DEPTH];
   int                 tq_count;
   logic [15:0]        tq_pending;

   timer_req_type   req_backlog [$];
   timer_reply_type replies_due [$];
   timer_req_type   driving_item;

   int  mismatches;
   int  reqs_taken;
   int  words_checked;
   int  expiries_seen;
   int  waits_seen;
   int  refusals_seen;
   int  send_idle;
   int  recv_stall;
   int  idle_cycles;
   bit  quiet_phase;

   always #10 clock = ~clock;

   // a lies after b when the wrapped difference b - a is negative
   function automatic bit is_after(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = b - a;
      return d[31];
   endfunction

   function automatic int gap_len(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   function automatic void queue_reply(kind_type kind, logic [ID_BITS-1:0] id,
                                       logic [WAIT_BITS-1:0] wait_ms, logic last);
      timer_reply_type r;
      r.kind    = kind;
      r.id      = id;
      r.wait_ms = wait_ms;
      r.last    = last;
      replies_due.push_back(r);
   endfunction

   function automatic void drop_entry(int pos);
      int i;
      for (i = pos; i + 1 < tq_count; i++) begin
         tq_ids[i]       = tq_ids[i + 1];
         tq_deadlines[i] = tq_deadlines[i + 1];
      end
      tq_count--;
   endfunction

   function automatic void compute_timer_replies(timer_req_type rq);
      int          pos;
      int          i;
      bit          found;
      logic [31:0] w;
      logic [ID_BITS-1:0] hid;
      case (rq.code)
         REQ_ADD: begin
            if (tq_pending[rq.id]) begin
               queue_reply(KIND_BUSY, '0, '0, 1'b1);
            end else if (tq_count >= TQ_DEPTH) begin
               queue_reply(KIND_FULL, '0, '0, 1'b1);
            end else begin
               // behind every entry that is not later: FIFO among equal deadlines
               pos = 0;
               while (pos < tq_count && !is_after(tq_deadlines[pos], rq.deadline_ms)) pos++;
               for (i = tq_count; i > pos; i--) begin
                  tq_ids[i]       = tq_ids[i - 1];
                  tq_deadlines[i] = tq_deadlines[i - 1];
               end
               tq_ids[pos]       = rq.id;
               tq_deadlines[pos] = rq.deadline_ms;
               tq_count++;
               tq_pending[rq.id] = 1'b1;
               queue_reply(KIND_OK, '0, '0, 1'b1);
            end
         end
         REQ_DEL: begin
            if (!tq_pending[rq.id]) begin
               queue_reply(KIND_ABSENT, '0, '0, 1'b1);
            end else begin
               tq_pending[rq.id] = 1'b0;
               found = 1'b0;
               for (pos = 0; pos < tq_count && !found; pos++) begin
                  if (tq_ids[pos] == rq.id) begin
                     drop_entry(pos);
                     found = 1'b1;
                  end
               end
               queue_reply(found ? KIND_OK : KIND_ABSENT, '0, '0, 1'b1);
            end
         end
         REQ_ADV: begin
            while (tq_count > 0 && !is_after(tq_deadlines[0], rq.now_ms)) begin
               hid = tq_ids[0];
               drop_entry(0);
               tq_pending[hid] = 1'b0;
               queue_reply(KIND_EXPIRED, hid, '0, 1'b0);
            end
            if (tq_count > 0) begin
               w = tq_deadlines[0] - rq.now_ms;
               // saturate at the widest wait the port can carry
               queue_reply(KIND_WAIT, '0, (w > 32'h7FFF_FFFF) ? WAIT_MAX : w[WAIT_BITS-1:0],
                           1'b1);
            end else begin
               queue_reply(KIND_EMPTY, '0, '0, 1'b1);
            end
         end
         default: queue_reply(KIND_OK, '0, '0, 1'b1);
      endcase
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= 25) $display("mismatch at %0t: %s", $realtime, what);
   endtask

   task automatic push_req(req_code_type code, int id, logic [31:0] deadline_ms,
                           logic [31:0] now_ms);
      timer_req_type rq;
      rq.code        = code;
      rq.id          = id[ID_BITS-1:0];
      rq.deadline_ms = deadline_ms;
      rq.now_ms      = now_ms;
      req_backlog.push_back(rq);
   endtask

   // driver: present the next word once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_idle = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            compute_timer_replies(driving_item);
            reqs_taken++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_idle > 0) begin
               send_idle--;
               req_if.valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               driving_item = req_backlog.pop_front();
               req_if.req_type    <= driving_item.code;
               req_if.timer_id    <= driving_item.id;
               req_if.deadline_ms <= driving_item.deadline_ms;
               req_if.now_ms      <= driving_item.now_ms;
               req_if.valid       <= 1'b1;
               send_idle = gap_len(quiet_phase);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result word against the oldest one due
   always @(posedge clock) begin
      timer_reply_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            words_checked++;
            if (replies_due.size() == 0) begin
               report_mismatch($sformatf("word with nothing due: kind %0d id %0d wait %0d last %0d",
                  rsp_if.result_kind, rsp_if.expired_id, rsp_if.wait_ms, rsp_if.last_result));
            end else begin
               want = replies_due.pop_front();
               if (rsp_if.result_kind !== want.kind)
                  report_mismatch($sformatf("result_kind %0d, want %0d",
                     rsp_if.result_kind, want.kind));
               if (rsp_if.expired_id !== want.id)
                  report_mismatch($sformatf("expired_id %0d, want %0d",
                     rsp_if.expired_id, want.id));
               if (rsp_if.wait_ms !== want.wait_ms)
                  report_mismatch($sformatf("wait_ms %0d, want %0d",
                     rsp_if.wait_ms, want.wait_ms));
               if (rsp_if.last_result !== want.last)
                  report_mismatch($sformatf("last_result %0d, want %0d",
                     rsp_if.last_result, want.last));
               case (want.kind)
                  KIND_EXPIRED: expiries_seen++;
                  KIND_WAIT:    waits_seen++;
                  KIND_BUSY, KIND_ABSENT, KIND_FULL: refusals_seen++;
                  default: ;
               endcase
            end
            recv_stall = gap_len(quiet_phase);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // watchdog: end the run when neither channel moves for too long
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
         $display("[sorted_deadline_timer_queue] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [31:0] gen_now;
      logic [31:0] last_dl;
      logic [31:0] dl;
      int          n;
      int          r;
      int          id;
      int          i;

      clock = 1'b0;
      reset = 1'b1;
      req_if.valid       = 1'b0;
      req_if.req_type    = '0;
      req_if.timer_id    = '0;
      req_if.deadline_ms = '0;
      req_if.now_ms      = '0;
      rsp_if.ready       = 1'b0;
      tq_count    = 0;
      tq_pending  = '0;
      mismatches  = 0;
      reqs_taken  = 0;
      words_checked = 0;
      expiries_seen = 0;
      waits_seen  = 0;
      refusals_seen = 0;
      idle_cycles = 0;
      quiet_phase = 1'b0;

      // directed: empty queue, unused code, refusals, saturated wait, ties and wrap
      push_req(REQ_ADV, 0, 32'h0, 32'h0);
      push_req(REQ_NOP, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_req(REQ_DEL, 7, 32'h0, 32'h0);
      push_req(REQ_ADD, 9, 32'h8000_0010, 32'h0);
      push_req(REQ_ADV, 0, 32'h0, 32'h0000_0010);
      push_req(REQ_ADV, 0, 32'h0, 32'h8000_0010);
      push_req(REQ_ADD, 0, 32'h0, 32'h0);
      push_req(REQ_ADD, 15, 32'hFFFF_FFFF, 32'h0);
      push_req(REQ_ADD, 0, 32'h1234_5678, 32'h0);
      for (i = 1; i <= 10; i++) begin
         if (i < 5) dl = 32'd100;
         else if (i == 5) dl = 32'h7FFF_FFFF;
         else if (i == 6) dl = 32'h8000_0000;
         else dl = i * 32'h1111_1111;
         push_req(REQ_ADD, i, dl, 32'h0);
      end
      push_req(REQ_DEL, 15, 32'h0, 32'h0);
      push_req(REQ_DEL, 15, 32'h0, 32'h0);
      push_req(REQ_ADV, 0, 32'h0, 32'd100);
      push_req(REQ_ADV, 0, 32'h0, 32'h7FFF_FFFF);
      push_req(REQ_ADV, 0, 32'h0, 32'hFFFF_0000);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // random: mostly near-term deadlines against a moving clock
      gen_now = $urandom;
      last_dl = gen_now;
      for (n = 0; n < RANDOM_REQS; n++) begin
         while (req_backlog.size() >= 2) @(negedge clock);
         if (n == RANDOM_REQS / 2) gen_now = 32'hFFFF_FF00;
         quiet_phase = ((n / 50) % 4) == 3;
         r = $urandom_range(0, 99);
         if (r < 45) begin
            id = $urandom_range(0, 15);
            if (tq_pending != 16'hFFFF && $urandom_range(0, 9) != 0)
               while (tq_pending[id]) id = $urandom_range(0, 15);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: dl = gen_now + $urandom_range(0, 300);
               6: dl = last_dl;
               7: dl = gen_now - $urandom_range(0, 50);
               8: dl = $urandom;
               default: dl = gen_now + 32'h7FFF_FF00 + $urandom_range(0, 511);
            endcase
            last_dl = dl;
            push_req(REQ_ADD, id, dl, $urandom);
         end else if (r < 65) begin
            id = $urandom_range(0, 15);
            if (tq_pending != 16'h0 && $urandom_range(0, 4) != 0)
               while (!tq_pending[id]) id = $urandom_range(0, 15);
            push_req(REQ_DEL, id, $urandom, $urandom);
         end else if (r < 97) begin
            case ($urandom_range(0, 19))
               0: gen_now = $urandom;
               1, 2, 3: gen_now = gen_now + $urandom_range(0, 2000);
               default: gen_now = gen_now + $urandom_range(0, 150);
            endcase
            push_req(REQ_ADV, $urandom_range(0, 15), $urandom, gen_now);
         end else begin
            push_req(REQ_NOP, $urandom_range(0, 15), $urandom, $urandom);
         end
      end

      while (req_backlog.size() != 0 || req_if.valid || replies_due.size() != 0)
         @(negedge clock);
      repeat (40) @(negedge clock);

      $display("ran %0d requests, checked %0d result words", reqs_taken, words_checked);
      $display("seen %0d expiries, %0d wait times, %0d refusals",
               expiries_seen, waits_seen, refusals_seen);
      if (mismatches == 0) begin
         $display("[sorted_deadline_timer_queue] OK");
      end else begin
         $display("[sorted_deadline_timer_queue] ERROR");
      end
      $finish;
   end

endmodule
